[sv/bef_pkg.sv]
// shared types and constants of the boundary edge flux unit
package bef_pkg;

    localparam int W_VAL  = 32;
    localparam int W_FLUX = 48;
    localparam int W_ADDR = 5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_BV1  = 3'd1;
    localparam logic [2:0] REG_BV2  = 3'd2;
    localparam logic [2:0] REG_BV3  = 3'd3;
    localparam logic [2:0] REG_BV4  = 3'd4;
    localparam logic [2:0] REG_HC   = 3'd5;
    localparam logic [2:0] REG_AMB  = 3'd6;

    localparam logic [W_VAL-1:0] AMB_RESET = 32'd19202048;

    localparam logic [3:0] CODE_FIRST = 4'd1;
    localparam logic [3:0] CODE_LAST  = 4'd4;

    localparam logic [W_FLUX-1:0] FLUX_MAX = {1'b0, {(W_FLUX-1){1'b1}}};
    localparam logic [W_FLUX-1:0] FLUX_MIN = {1'b1, {(W_FLUX-1){1'b0}}};

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // back pipeline stage map
    localparam int NSQ    = 33;
    localparam int NDIV   = 48;
    localparam int S_SUM  = 1;
    localparam int S_SQ0  = 2;
    localparam int S_OVF  = S_SQ0 + NSQ;
    localparam int S_DV0  = S_OVF + 1;
    localparam int S_FIN  = S_DV0 + NDIV;
    localparam int NSTG   = S_FIN + 1;

    typedef struct packed {
        logic                  mode;
        logic [3:0][W_VAL-1:0] bval;
        logic [W_VAL-1:0]      hc;
        logic [W_VAL-1:0]      amb;
    } t_cfg;

    // one classified edge
    typedef struct packed {
        logic        wr;
        logic        div;
        logic        conv;
        logic        neg;
        logic [32:0] adiff;
        logic [32:0] ax;
        logic [32:0] ay;
    } t_item;

endpackage

[sv/bef_queue.sv]
// short queue of classified edges between front and back
module bef_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bef_pkg::t_item i_item,
    input  logic           i_pop,
    output bef_pkg::t_item o_item,
    output logic           o_nempty,
    output logic           o_nfull
);

    bef_pkg::t_item r_mem [bef_pkg::QDEPTH];
    logic [bef_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [bef_pkg::QPTR_W:0]   r_cnt;

    assign o_nempty = (r_cnt != '0);
    assign o_nfull  = (r_cnt != (bef_pkg::QPTR_W+1)'(bef_pkg::QDEPTH));
    assign o_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/bef_front.sv]
// front end: accepts an edge, picks the boundary value and forms magnitudes
module bef_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bef_pkg::t_cfg           i_cfg,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [3:0]              i_boundary_code,
    input  logic signed [31:0]      i_cell_value,
    input  logic signed [31:0]      i_centroid_x,
    input  logic signed [31:0]      i_centroid_y,
    input  logic signed [31:0]      i_vertex_x,
    input  logic signed [31:0]      i_vertex_y,
    input  logic                    i_q_nfull,
    output logic                    o_q_push,
    output bef_pkg::t_item          o_item
);

    logic           r_vld;
    bef_pkg::t_item r_item;
    bef_pkg::t_item n_item;

    logic        is_bnd;
    logic [3:0]  cm1;
    logic [31:0] sel;
    logic [32:0] diff, dx, dy;
    logic        accept;

    always_comb begin
        is_bnd = (i_boundary_code inside {[bef_pkg::CODE_FIRST:bef_pkg::CODE_LAST]});
        cm1    = i_boundary_code - 4'd1;
        sel    = i_cfg.mode ? i_cfg.amb : i_cfg.bval[cm1[1:0]];
        diff   = {sel[31], sel} - {i_cell_value[31], i_cell_value};
        dx     = {i_centroid_x[31], i_centroid_x} - {i_vertex_x[31], i_vertex_x};
        dy     = {i_centroid_y[31], i_centroid_y} - {i_vertex_y[31], i_vertex_y};
        n_item.wr    = is_bnd;
        n_item.div   = is_bnd && !i_cfg.mode;
        n_item.conv  = is_bnd && i_cfg.mode && (i_boundary_code == bef_pkg::CODE_FIRST);
        n_item.neg   = diff[32];
        n_item.adiff = diff[32] ? -diff : diff;
        n_item.ax    = dx[32] ? -dx : dx;
        n_item.ay    = dy[32] ? -dy : dy;
    end

    assign o_q_push = r_vld && i_q_nfull;
    assign o_full   = r_vld && !i_q_nfull;
    assign o_item   = r_item;
    assign accept   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

endmodule

[sv/bef_back.sv]
// back end: squares and convective product, bitwise square root, restoring divide, saturation
module bef_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [31:0]             i_hc,
    input  bef_pkg::t_item          i_item,
    input  logic                    i_q_nempty,
    output logic                    o_q_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic signed [47:0]      o_flux,
    output logic                    o_flux_written,
    output logic                    o_zero_distance
);

    typedef struct packed {
        logic        vld;
        logic        wr;
        logic        div;
        logic        conv;
        logic        zd;
        logic        neg;
        logic [32:0] adiff;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [65:0] sqx;
        logic [65:0] sqy;
        logic [56:0] pmag;
        logic [65:0] rad;
        logic [32:0] root;
        logic [33:0] rem;
        logic [64:0] num;
        logic [47:0] q;
        logic        ovf;
        logic [47:0] flux;
    } t_pipe;

    t_pipe r_stg [bef_pkg::NSTG];
    t_pipe n_stg [bef_pkg::NSTG];
    logic  en;

    function automatic logic [47:0] sat(input logic neg, input logic big,
                                        input logic [47:0] mag);
        if (neg) begin
            return (big || mag[47]) ? bef_pkg::FLUX_MIN : -mag;
        end
        return (big || mag[47]) ? bef_pkg::FLUX_MAX : mag;
    endfunction

    assign en      = !r_stg[bef_pkg::NSTG-1].vld || i_pop;
    assign o_q_pop = en && i_q_nempty;

    genvar k;
    generate
        for (k = 0; k < bef_pkg::NSTG; k++) begin : g_stg
            if (k == 0) begin : g_mul
                logic [64:0] prod;
                always_comb begin
                    prod = {33'b0, i_hc} * {32'b0, i_item.adiff};
                    n_stg[k]       = '0;
                    n_stg[k].vld   = o_q_pop;
                    n_stg[k].wr    = i_item.wr;
                    n_stg[k].div   = i_item.div;
                    n_stg[k].conv  = i_item.conv;
                    n_stg[k].neg   = i_item.neg;
                    n_stg[k].adiff = i_item.adiff;
                    n_stg[k].ax    = i_item.ax;
                    n_stg[k].ay    = i_item.ay;
                    n_stg[k].sqx   = i_item.ax * i_item.ax;
                    n_stg[k].sqy   = i_item.ay * i_item.ay;
                    n_stg[k].pmag  = prod[64:8];
                end
            end else if (k == bef_pkg::S_SUM) begin : g_sum
                always_comb begin
                    n_stg[k]      = r_stg[k-1];
                    n_stg[k].rad  = r_stg[k-1].sqx + r_stg[k-1].sqy;
                    n_stg[k].num  = {r_stg[k-1].adiff, 32'b0};
                    n_stg[k].zd   = r_stg[k-1].div && (r_stg[k-1].ax == '0)
                                    && (r_stg[k-1].ay == '0);
                    n_stg[k].root = '0;
                    n_stg[k].rem  = '0;
                end
            end else if (k < bef_pkg::S_OVF) begin : g_sqrt
                // one root bit per stage, two radicand bits consumed
                localparam int P = 65 - 2 * (k - bef_pkg::S_SQ0);
                logic [35:0] t, trial;
                always_comb begin
                    t     = {r_stg[k-1].rem, r_stg[k-1].rad[P -: 2]};
                    trial = {1'b0, r_stg[k-1].root, 2'b01};
                    n_stg[k] = r_stg[k-1];
                    if (t >= trial) begin
                        n_stg[k].rem  = 34'(t - trial);
                        n_stg[k].root = {r_stg[k-1].root[31:0], 1'b1};
                    end else begin
                        n_stg[k].rem  = t[33:0];
                        n_stg[k].root = {r_stg[k-1].root[31:0], 1'b0};
                    end
                end
            end else if (k == bef_pkg::S_OVF) begin : g_ovf
                always_comb begin
                    n_stg[k]     = r_stg[k-1];
                    n_stg[k].ovf = {16'b0, r_stg[k-1].num} >= {r_stg[k-1].root, 48'b0};
                    n_stg[k].q   = '0;
                end
            end else if (k < bef_pkg::S_FIN) begin : g_div
                // restoring divide, one quotient bit per stage
                localparam int B = bef_pkg::S_FIN - 1 - k;
                logic [80:0] tv;
                always_comb begin
                    tv       = {48'b0, r_stg[k-1].root} << B;
                    n_stg[k] = r_stg[k-1];
                    if ({16'b0, r_stg[k-1].num} >= tv) begin
                        n_stg[k].num  = r_stg[k-1].num - tv[64:0];
                        n_stg[k].q[B] = 1'b1;
                    end
                end
            end else begin : g_fin
                always_comb begin
                    n_stg[k] = r_stg[k-1];
                    if (r_stg[k-1].div) begin
                        if (r_stg[k-1].zd) begin
                            if (r_stg[k-1].adiff == '0) begin
                                n_stg[k].flux = '0;
                            end else begin
                                n_stg[k].flux = r_stg[k-1].neg ? bef_pkg::FLUX_MIN
                                                               : bef_pkg::FLUX_MAX;
                            end
                        end else begin
                            n_stg[k].flux = sat(r_stg[k-1].neg, r_stg[k-1].ovf,
                                                r_stg[k-1].q);
                        end
                    end else if (r_stg[k-1].conv) begin
                        n_stg[k].flux = sat(r_stg[k-1].neg, |r_stg[k-1].pmag[56:48],
                                            r_stg[k-1].pmag[47:0]);
                    end else begin
                        n_stg[k].flux = '0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stg[k].vld <= 1'b0;
                end else if (en) begin
                    r_stg[k] <= n_stg[k];
                end
            end
        end
    endgenerate

    assign o_empty         = !r_stg[bef_pkg::NSTG-1].vld;
    assign o_flux          = r_stg[bef_pkg::NSTG-1].flux;
    assign o_flux_written  = r_stg[bef_pkg::NSTG-1].wr;
    assign o_zero_distance = r_stg[bef_pkg::NSTG-1].zd;

endmodule

[sv/boundary_edge_flux_unit.sv]
// path: an input passes 1 front register, the queue and 85 back stages before its result
// reaches the ports
// throughput: one edge per cycle while results are popped; the back pipeline advances whenever its last stage
// is empty or popped, 33 square-root stages, 1 overflow stage and 48 divide stages set the depth
// reset: synchronous active-low i_rst_n empties front, queue and pipeline;
// registers reset to 0 except ambient_temp, which resets to 293.0
module boundary_edge_flux_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // edge input
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [3:0]                   i_boundary_code,
    input  logic signed [31:0]           i_cell_value,
    input  logic signed [31:0]           i_centroid_x,
    input  logic signed [31:0]           i_centroid_y,
    input  logic signed [31:0]           i_vertex_x,
    input  logic signed [31:0]           i_vertex_y,
    // result output
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic signed [47:0]           o_flux,
    output logic                         o_flux_written,
    output logic                         o_zero_distance,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bef_pkg::W_ADDR-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // configuration registers
    logic                  r_mode;
    logic [3:0][31:0]      r_bval;
    logic [31:0]           r_hc;
    logic [31:0]           r_amb;
    bef_pkg::t_cfg         cfg;
    logic                  wr_en;
    logic [2:0]            idx;

    bef_pkg::t_item        f_item, q_item;
    logic                  q_push, q_pop, q_nempty, q_nfull;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_bval <= '0;
            r_hc   <= '0;
            r_amb  <= bef_pkg::AMB_RESET;
        end else if (wr_en) begin
            case (idx)
                bef_pkg::REG_MODE: r_mode    <= pwdata[0];
                bef_pkg::REG_BV1:  r_bval[0] <= pwdata;
                bef_pkg::REG_BV2:  r_bval[1] <= pwdata;
                bef_pkg::REG_BV3:  r_bval[2] <= pwdata;
                bef_pkg::REG_BV4:  r_bval[3] <= pwdata;
                bef_pkg::REG_HC:   r_hc      <= pwdata;
                bef_pkg::REG_AMB:  r_amb     <= pwdata;
                default:           r_mode    <= r_mode;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (idx)
            bef_pkg::REG_MODE: prdata = {31'b0, r_mode};
            bef_pkg::REG_BV1:  prdata = r_bval[0];
            bef_pkg::REG_BV2:  prdata = r_bval[1];
            bef_pkg::REG_BV3:  prdata = r_bval[2];
            bef_pkg::REG_BV4:  prdata = r_bval[3];
            bef_pkg::REG_HC:   prdata = r_hc;
            bef_pkg::REG_AMB:  prdata = r_amb;
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        cfg.mode = r_mode;
        cfg.bval = r_bval;
        cfg.hc   = r_hc;
        cfg.amb  = r_amb;
    end

    // front: classify the edge and form the difference and offsets
    bef_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_boundary_code (i_boundary_code),
        .i_cell_value    (i_cell_value),
        .i_centroid_x    (i_centroid_x),
        .i_centroid_y    (i_centroid_y),
        .i_vertex_x      (i_vertex_x),
        .i_vertex_y      (i_vertex_y),
        .i_q_nfull       (q_nfull),
        .o_q_push        (q_push),
        .o_item          (f_item)
    );

    // decoupling queue, lets front keep taking edges while back stalls, until the queue is full
    bef_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (f_item),
        .i_pop    (q_pop),
        .o_item   (q_item),
        .o_nempty (q_nempty),
        .o_nfull  (q_nfull)
    );

    // back: distance, quotient or convective product, saturation
    bef_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hc            (r_hc),
        .i_item          (q_item),
        .i_q_nempty      (q_nempty),
        .o_q_pop         (q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_flux          (o_flux),
        .o_flux_written  (o_flux_written),
        .o_zero_distance (o_zero_distance)
    );

endmodule
